[rtl/lfu_pkg.sv]
// ============================================================================
// LFU cache package
// Shared widths, codes, state encoding and scan status for the LFU cache.
// ============================================================================
package lfu_pkg;

    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int STAMP_W      = 64;
    localparam int CAP_W        = 5;
    localparam int ENTRIES_DEF  = 16;
    localparam int COUNT_W_DEF  = 16;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Status of one pass over the entry memory.
    typedef struct packed {
        logic match_found;
        logic victim_found;
        logic free_found;
    } scan_flags_t;

endpackage

[rtl/lfu_entry_mem.sv]
// ============================================================================
// LFU entry memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ============================================================================
module lfu_entry_mem #(
    parameter int DEPTH  = lfu_pkg::ENTRIES_DEF,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 144
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lfu_scan_unit.sv]
// ============================================================================
// LFU scan unit
// Walks the entries read from memory, one per cycle, and keeps the key match,
// the eviction candidate and the lowest free slot.
// ============================================================================
module lfu_scan_unit #(
    parameter int IDX_W       = 4,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_W_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        rd_vld,
    input  logic [IDX_W-1:0]            rd_idx,
    input  logic                        entry_valid,
    input  logic [lfu_pkg::KEY_W-1:0]   entry_key,
    input  logic [lfu_pkg::VAL_W-1:0]   entry_value,
    input  logic [COUNT_WIDTH-1:0]      entry_count,
    input  logic [lfu_pkg::STAMP_W-1:0] entry_stamp,
    input  logic [lfu_pkg::KEY_W-1:0]   lookup_key,
    output lfu_pkg::scan_flags_t        flags,
    output logic [IDX_W-1:0]            match_idx,
    output logic [lfu_pkg::VAL_W-1:0]   match_value,
    output logic [COUNT_WIDTH-1:0]      match_count,
    output logic [IDX_W-1:0]            victim_idx,
    output logic [IDX_W-1:0]            free_idx
);

    lfu_pkg::scan_flags_t        flags_reg;
    logic [IDX_W-1:0]            match_idx_reg;
    logic [lfu_pkg::VAL_W-1:0]   match_value_reg;
    logic [COUNT_WIDTH-1:0]      match_count_reg;
    logic [IDX_W-1:0]            victim_idx_reg;
    logic [COUNT_WIDTH-1:0]      victim_count_reg;
    logic [lfu_pkg::STAMP_W-1:0] victim_stamp_reg;
    logic [IDX_W-1:0]            free_idx_reg;

    logic take_match;
    logic take_victim;
    logic take_free;

    // Lower count wins; on equal counts the older stamp wins.
    assign take_match  = rd_vld && entry_valid && (entry_key == lookup_key);
    assign take_victim = rd_vld && entry_valid &&
                         (!flags_reg.victim_found ||
                          (entry_count < victim_count_reg) ||
                          ((entry_count == victim_count_reg) &&
                           (entry_stamp < victim_stamp_reg)));
    assign take_free   = rd_vld && !entry_valid && !flags_reg.free_found;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            flags_reg <= '0;
        end else begin
            if (take_match) begin
                flags_reg.match_found <= 1'b1;
            end
            if (take_victim) begin
                flags_reg.victim_found <= 1'b1;
            end
            if (take_free) begin
                flags_reg.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_match) begin
            match_idx_reg   <= rd_idx;
            match_value_reg <= entry_value;
            match_count_reg <= entry_count;
        end
        if (take_victim) begin
            victim_idx_reg   <= rd_idx;
            victim_count_reg <= entry_count;
            victim_stamp_reg <= entry_stamp;
        end
        if (take_free) begin
            free_idx_reg <= rd_idx;
        end
    end

    assign flags       = flags_reg;
    assign match_idx   = match_idx_reg;
    assign match_value = match_value_reg;
    assign match_count = match_count_reg;
    assign victim_idx  = victim_idx_reg;
    assign free_idx    = free_idx_reg;

endmodule

[rtl/lfu_cache_policy_core.sv]
// ============================================================================
// LFU cache policy core
// Key-value store with least-frequently-used replacement, held in one entry
// memory that is scanned once per request and written back at most once.
// ============================================================================
//
//   Channel  Direction  Payload
//   s_       in         tdata = {write_value, lookup_key}, tuser = req_type
//   m_       out        tdata = read_value, tuser = hit
//   cfg_     in         cfg_data = capacity_limit
//
// A request passes through these steps in order: accept, one memory read per
// entry, a drain of the read pipeline, a write-back and handing the result to
// the output register; the entry memory has a single read port. Reset clears
// valid bits, live count and sequence counter and sets the capacity to
// CAP_RESET at once; no clearing pass is needed. While a result waits in the
// output register the next request is accepted, and it holds in its result
// step until the output register frees up.
module lfu_cache_policy_core #(
    parameter int ENTRIES     = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_W_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic                       s_tuser,   // [0] req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [31:0] read_value
    output logic                       m_tuser,   // [0] hit
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]  cfg_data
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LIVE_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (LIVE_W > lfu_pkg::CAP_W) ? LIVE_W : lfu_pkg::CAP_W;
    localparam int KEY_W   = lfu_pkg::KEY_W;
    localparam int VAL_W   = lfu_pkg::VAL_W;
    localparam int STAMP_W = lfu_pkg::STAMP_W;
    localparam int MEM_W   = KEY_W + VAL_W + COUNT_WIDTH + STAMP_W;

    // Entry word layout, from the lowest bit: stamp, count, value, key.
    localparam int CNT_LO = STAMP_W;
    localparam int VAL_LO = STAMP_W + COUNT_WIDTH;
    localparam int KEY_LO = STAMP_W + COUNT_WIDTH + VAL_W;

    lfu_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]         scan_addr_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [ENTRIES-1:0]       valid_reg;
    logic [LIVE_W-1:0]        live_reg;
    logic [STAMP_W-1:0]       seq_reg;
    logic [lfu_pkg::CAP_W-1:0] cap_reg;

    logic                     req_put_reg;
    logic [KEY_W-1:0]         req_key_reg;
    logic [VAL_W-1:0]         req_val_reg;
    logic                     res_hit_reg;
    logic [VAL_W-1:0]         res_val_reg;

    logic                     m_tvalid_reg;
    logic [VAL_W-1:0]         m_tdata_reg;
    logic                     m_tuser_reg;

    logic                     accept;
    logic                     scan_last;
    logic                     mem_re;
    logic                     mem_we;
    logic                     out_load;
    logic [MEM_W-1:0]         mem_rdata;
    logic [MEM_W-1:0]         mem_wdata;
    logic [IDX_W-1:0]         mem_waddr;

    lfu_pkg::scan_flags_t     flags;
    logic [IDX_W-1:0]         match_idx;
    logic [VAL_W-1:0]         match_value;
    logic [COUNT_WIDTH-1:0]   match_count;
    logic [IDX_W-1:0]         victim_idx;
    logic [IDX_W-1:0]         free_idx;

    logic [CMP_W-1:0]         cap_eff;
    logic                     cap_zero;
    logic                     bump_en;
    logic                     ins_req;
    logic                     evict;
    logic                     use_victim;
    logic [IDX_W-1:0]         slot;
    logic                     ins_en;
    logic                     do_write;
    logic [COUNT_WIDTH-1:0]   bumped_count;
    logic [VAL_W-1:0]         new_value;
    logic [COUNT_WIDTH-1:0]   new_count;
    logic [VAL_W-1:0]         result_value;

    assign accept    = s_tvalid && s_tready;
    assign scan_last = (scan_addr_reg == IDX_W'(ENTRIES - 1));
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Entry memory and scan
    // ------------------------------------------------------------------
    lfu_entry_mem #(
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (MEM_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (scan_addr_reg),
        .rd_data (mem_rdata)
    );

    lfu_scan_unit #(
        .IDX_W       (IDX_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (accept),
        .rd_vld      (rd_vld_reg),
        .rd_idx      (rd_idx_reg),
        .entry_valid (valid_reg[rd_idx_reg]),
        .entry_key   (mem_rdata[KEY_LO +: KEY_W]),
        .entry_value (mem_rdata[VAL_LO +: VAL_W]),
        .entry_count (mem_rdata[CNT_LO +: COUNT_WIDTH]),
        .entry_stamp (mem_rdata[0 +: STAMP_W]),
        .lookup_key  (req_key_reg),
        .flags       (flags),
        .match_idx   (match_idx),
        .match_value (match_value),
        .match_count (match_count),
        .victim_idx  (victim_idx),
        .free_idx    (free_idx)
    );

    // ------------------------------------------------------------------
    // Write-back decision
    // ------------------------------------------------------------------
    always_comb begin
        if (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign cap_zero = (cap_reg == '0);
    assign bump_en  = flags.match_found && ((req_put_reg == lfu_pkg::REQ_GET) || !cap_zero);
    assign ins_req  = (req_put_reg == lfu_pkg::REQ_PUT) && !cap_zero && !flags.match_found;
    assign evict    = ins_req && (CMP_W'(live_reg) >= cap_eff) && flags.victim_found;

    // The freed victim slot counts as free when it lies below the first free slot.
    assign use_victim = evict && (!flags.free_found || (victim_idx < free_idx));
    assign slot       = use_victim ? victim_idx : free_idx;
    assign ins_en     = ins_req && (evict || flags.free_found);
    assign do_write   = bump_en || ins_en;

    assign bumped_count = (match_count == {COUNT_WIDTH{1'b1}}) ? match_count
                                                                : match_count + 1'b1;
    assign new_value = (bump_en && (req_put_reg == lfu_pkg::REQ_GET)) ? match_value
                                                                      : req_val_reg;
    assign new_count = bump_en ? bumped_count : COUNT_WIDTH'(1);
    assign mem_waddr = bump_en ? match_idx : slot;
    assign mem_wdata = {req_key_reg, new_value, new_count, seq_reg};

    assign result_value = (flags.match_found && (req_put_reg == lfu_pkg::REQ_GET))
                        ? match_value : lfu_pkg::MISS_VALUE;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                mem_re = 1'b1;
                if (scan_last) begin
                    state_next = lfu_pkg::ST_DRAIN;
                end
            end
            lfu_pkg::ST_DRAIN: begin
                state_next = lfu_pkg::ST_UPDATE;
            end
            lfu_pkg::ST_UPDATE: begin
                mem_we     = do_write;
                state_next = lfu_pkg::ST_RESULT;
            end
            lfu_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= mem_re;
            if (accept) begin
                scan_addr_reg <= '0;
            end else if (mem_re && !scan_last) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_addr_reg;
        if (accept) begin
            req_put_reg <= s_tuser;
            req_key_reg <= s_tdata[KEY_W-1:0];
            req_val_reg <= s_tdata[KEY_W +: VAL_W];
        end
        if (state_reg == lfu_pkg::ST_UPDATE) begin
            res_hit_reg <= flags.match_found;
            res_val_reg <= result_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            live_reg  <= '0;
            seq_reg   <= '0;
            cap_reg   <= lfu_pkg::CAP_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (mem_we) begin
                seq_reg <= seq_reg + 1'b1;
            end
            if (mem_we && ins_en) begin
                if (evict) begin
                    valid_reg[victim_idx] <= 1'b0;
                end else begin
                    live_reg <= live_reg + 1'b1;
                end
                valid_reg[slot] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= res_val_reg;
            m_tuser_reg <= res_hit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_live_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg == LIVE_W'($countones(valid_reg)))
        else $error("live count differs from the number of valid entries");

    a_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == lfu_pkg::ST_UPDATE))
        else $error("entry memory written outside the write-back step");

    a_seq_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !mem_we |=> $stable(seq_reg))
        else $error("sequence counter moved without an entry write");

    a_single_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfu_pkg::ST_UPDATE) |-> !(bump_en && ins_en))
        else $error("hit update and insertion selected together");

    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfu_pkg::ST_DRAIN) |-> (rd_vld_reg && scan_last))
        else $error("scan drained before the last entry was read");

endmodule
